@@ hdl/ncl_pkg.sv @@
// ----------------------------------------------------------------------------
// ncl_pkg
// Shared types and codes of the nibble-checked command link.
// ----------------------------------------------------------------------------
package ncl_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int CODE_W          = 4;
  localparam int DATA_W          = 8;
  localparam int ITEM_W          = CODE_W + DATA_W;

  typedef enum logic [1:0] {
    CMD_QUEUE = 2'd0,
    CMD_RX    = 2'd1,
    CMD_TX    = 2'd2,
    CMD_NONE  = 2'd3
  } ncl_command_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_REFUSED  = 2'd1,
    STS_MISMATCH = 2'd2,
    STS_EMPTY    = 2'd3
  } ncl_status_t;

  typedef enum logic [1:0] {
    EVT_NONE  = 2'd0,
    EVT_ALARM = 2'd1,
    EVT_KEY   = 2'd2
  } ncl_event_t;

  localparam logic [CODE_W-1:0] CODE_ALARM_LO = 4'd1;
  localparam logic [CODE_W-1:0] CODE_ALARM_HI = 4'd2;
  localparam logic [CODE_W-1:0] CODE_KEY      = 4'd6;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } ncl_state_t;

  typedef struct packed {
    logic accept;
    logic issue_read;
    logic load_imm;
    logic load_tx;
  } ncl_ctl_t;

  typedef struct packed {
    logic q_empty;
  } ncl_sts_t;

endpackage

@@ hdl/ncl_ram.sv @@
// ----------------------------------------------------------------------------
// ncl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ncl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ hdl/ncl_ctrl.sv @@
// ----------------------------------------------------------------------------
// ncl_ctrl
// Request sequencing and result register valid control.
// ----------------------------------------------------------------------------
module ncl_ctrl
  import ncl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_command,
  input  logic        out_stall,
  input  ncl_sts_t    sts,
  output logic        in_stall,
  output logic        out_valid,
  output ncl_ctl_t    ctl
);

  ncl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    ctl            = '0;
    ctl.accept     = (state_r == ST_IDLE) && in_valid && out_free;
    ctl.issue_read = ctl.accept && (in_command == CMD_TX) && !sts.q_empty;
    ctl.load_imm   = ctl.accept && !ctl.issue_read;
    ctl.load_tx    = (state_r == ST_READ);
  end

  assign in_stall = !((state_r == ST_IDLE) && out_free);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (ctl.issue_read) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (ctl.load_imm || ctl.load_tx) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ hdl/ncl_dpath.sv @@
// ----------------------------------------------------------------------------
// ncl_dpath
// Command ring, frame check and decode, alarm register and result register.
// ----------------------------------------------------------------------------
module ncl_dpath
  import ncl_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ncl_ctl_t          ctl,
  output ncl_sts_t          sts,
  input  logic              cfg_we,
  input  logic              cfg_link_enable,
  input  logic [1:0]        in_command,
  input  logic [CODE_W-1:0] in_out_code,
  input  logic [DATA_W-1:0] in_out_data,
  input  logic [7:0]        in_rx_first_byte,
  input  logic [7:0]        in_rx_second_byte,
  output logic [1:0]        out_status,
  output logic              out_tx_valid,
  output logic [7:0]        out_tx_first_byte,
  output logic [7:0]        out_tx_second_byte,
  output logic [1:0]        out_event_kind,
  output logic [15:0]       out_event_value,
  output logic [CODE_W-1:0] out_rx_code,
  output logic [DATA_W-1:0] out_rx_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_inc, rd_ptr_inc;
  logic [15:0]       alarm_r, alarm_nxt;
  logic              link_en_r;
  logic              q_full;
  logic              ram_we;
  logic [ITEM_W-1:0] ram_rdata;

  logic [CODE_W-1:0] rx_hi;
  logic [DATA_W-1:0] rx_d;
  logic              rx_ok;

  logic [1:0]        status_nxt;
  logic [1:0]        event_kind_nxt;
  logic [15:0]       event_value_nxt;
  logic [CODE_W-1:0] rx_code_nxt;
  logic [DATA_W-1:0] rx_data_nxt;
  logic [CODE_W-1:0] tx_code;
  logic [DATA_W-1:0] tx_data;

  assign wr_ptr_inc  = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_inc  = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
  assign q_full      = (wr_ptr_inc == rd_ptr_r);
  assign sts.q_empty = (rd_ptr_r == wr_ptr_r);

  assign ram_we = ctl.accept && (in_command == CMD_QUEUE) && link_en_r && !q_full;

  ncl_ram #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata ({in_out_code, in_out_data}),
    .re    (ctl.issue_read),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  assign wr_ptr_nxt = ram_we ? wr_ptr_inc : wr_ptr_r;
  assign rd_ptr_nxt = ctl.issue_read ? rd_ptr_inc : rd_ptr_r;

  assign rx_hi = in_rx_first_byte[7:4];
  assign rx_d  = {in_rx_first_byte[3:0], in_rx_second_byte[7:4]};
  assign rx_ok = (rx_hi == ~in_rx_second_byte[3:0]);

  always_comb begin
    status_nxt      = STS_OK;
    event_kind_nxt  = EVT_NONE;
    event_value_nxt = '0;
    rx_code_nxt     = '0;
    rx_data_nxt     = '0;
    alarm_nxt       = alarm_r;
    unique case (in_command)
      CMD_QUEUE: begin
        if (!link_en_r || q_full) begin
          status_nxt = STS_REFUSED;
        end
      end
      CMD_RX: begin
        if (!rx_ok) begin
          status_nxt = STS_MISMATCH;
        end else begin
          rx_code_nxt = rx_hi;
          rx_data_nxt = rx_d;
          priority if (rx_hi == CODE_ALARM_LO) begin
            alarm_nxt       = {alarm_r[15:8], rx_d};
            event_kind_nxt  = EVT_ALARM;
            event_value_nxt = alarm_nxt;
          end else if (rx_hi == CODE_ALARM_HI) begin
            alarm_nxt       = {rx_d, alarm_r[7:0]};
            event_kind_nxt  = EVT_ALARM;
            event_value_nxt = alarm_nxt;
          end else if (rx_hi == CODE_KEY) begin
            event_kind_nxt  = EVT_KEY;
            event_value_nxt = {8'h00, rx_d};
          end else begin
            event_kind_nxt  = EVT_NONE;
          end
        end
      end
      CMD_TX: begin
        if (sts.q_empty) begin
          status_nxt = STS_EMPTY;
        end
      end
      default: begin
        status_nxt = STS_OK;
      end
    endcase
  end

  assign tx_code = ram_rdata[ITEM_W-1:DATA_W];
  assign tx_data = ram_rdata[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r  <= '0;
      wr_ptr_r  <= '0;
      alarm_r   <= '0;
      link_en_r <= 1'b1;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      if (ctl.accept) begin
        alarm_r <= alarm_nxt;
      end
      if (cfg_we) begin
        link_en_r <= cfg_link_enable;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_tx) begin
      out_status         <= STS_OK;
      out_tx_valid       <= 1'b1;
      out_tx_first_byte  <= {tx_code, tx_data[7:4]};
      out_tx_second_byte <= {tx_data[3:0], ~tx_code};
      out_event_kind     <= EVT_NONE;
      out_event_value    <= '0;
      out_rx_code        <= '0;
      out_rx_data        <= '0;
    end else if (ctl.load_imm) begin
      out_status         <= status_nxt;
      out_tx_valid       <= 1'b0;
      out_tx_first_byte  <= '0;
      out_tx_second_byte <= '0;
      out_event_kind     <= event_kind_nxt;
      out_event_value    <= event_value_nxt;
      out_rx_code        <= rx_code_nxt;
      out_rx_data        <= rx_data_nxt;
    end
  end

endmodule

@@ hdl/nibble_checked_command_link.sv @@
// ----------------------------------------------------------------------------
// nibble_checked_command_link
// Host side of a two-byte serial command link with a command ring and
// nibble-checked receive decode.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_stall   command, outbound item, rx pair
//   out      output     out_valid / out_stall status, tx pair, event, rx decode
//   cfg      input      cfg_valid / cfg_ready link_enable
//
// Queue, receive and unused requests load the result register at acceptance;
// a transmit from a non-empty ring first reads the registered read port of
// the ring memory and loads the result register from it in the READ state.
// A new request is accepted whenever the result register is free or being
// drained in the same cycle, so back-to-back requests run at one per cycle
// apart from transmits. Reset is synchronous and leaves the ring empty,
// the alarm register zero and the link enabled.
// ----------------------------------------------------------------------------
module nibble_checked_command_link
  import ncl_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_command,
  input  logic [CODE_W-1:0] in_out_code,
  input  logic [DATA_W-1:0] in_out_data,
  input  logic [7:0]        in_rx_first_byte,
  input  logic [7:0]        in_rx_second_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic              out_tx_valid,
  output logic [7:0]        out_tx_first_byte,
  output logic [7:0]        out_tx_second_byte,
  output logic [1:0]        out_event_kind,
  output logic [15:0]       out_event_value,
  output logic [CODE_W-1:0] out_rx_code,
  output logic [DATA_W-1:0] out_rx_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_link_enable
);

  ncl_ctl_t ctl;
  ncl_sts_t sts;

  assign cfg_ready = 1'b1;

  ncl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .out_stall  (out_stall),
    .sts        (sts),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .ctl        (ctl)
  );

  ncl_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sts                (sts),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_link_enable    (cfg_link_enable),
    .in_command         (in_command),
    .in_out_code        (in_out_code),
    .in_out_data        (in_out_data),
    .in_rx_first_byte   (in_rx_first_byte),
    .in_rx_second_byte  (in_rx_second_byte),
    .out_status         (out_status),
    .out_tx_valid       (out_tx_valid),
    .out_tx_first_byte  (out_tx_first_byte),
    .out_tx_second_byte (out_tx_second_byte),
    .out_event_kind     (out_event_kind),
    .out_event_value    (out_event_value),
    .out_rx_code        (out_rx_code),
    .out_rx_data        (out_rx_data)
  );

endmodule

@@ hdl/ncl_checker.sv @@
// ----------------------------------------------------------------------------
// ncl_checker
// Port-level checks of the nibble-checked command link, bound to the top.
// ----------------------------------------------------------------------------
module ncl_checker
  import ncl_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_status,
  input logic              out_tx_valid,
  input logic [7:0]        out_tx_first_byte,
  input logic [7:0]        out_tx_second_byte,
  input logic [1:0]        out_event_kind,
  input logic [15:0]       out_event_value,
  input logic [CODE_W-1:0] out_rx_code,
  input logic [DATA_W-1:0] out_rx_data
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_tx_first_byte) && $stable(out_event_value))
    else $error("stalled result changed");

  a_tx_framing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_valid |->
      out_status == STS_OK && out_tx_second_byte[3:0] == ~out_tx_first_byte[7:4])
    else $error("transmit pair framing broken");

  a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STS_OK |->
      !out_tx_valid && out_event_kind == EVT_NONE && out_rx_code == '0)
    else $error("error result carries payload");

  a_key_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EVT_KEY |->
      out_rx_code == CODE_KEY && out_event_value == {8'h00, out_rx_data})
    else $error("key event inconsistent with decoded frame");

endmodule

bind nibble_checked_command_link ncl_checker u_ncl_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_status         (out_status),
  .out_tx_valid       (out_tx_valid),
  .out_tx_first_byte  (out_tx_first_byte),
  .out_tx_second_byte (out_tx_second_byte),
  .out_event_kind     (out_event_kind),
  .out_event_value    (out_event_value),
  .out_rx_code        (out_rx_code),
  .out_rx_data        (out_rx_data)
);

@@ verif/nibble_checked_command_link_tb.sv @@
// ----------------------------------------------------------------------------
// nibble_checked_command_link_tb
// Self-checking bench for the nibble-checked command link. A driver sends
// queue, receive, transmit and unused requests in random bursts while the
// receiver stalls on its own pattern. Every accepted request is run through
// a predictor of the command ring, the frame decoder and the alarm register.
// Each result is compared field by field with the oldest prediction. The
// link enable is toggled between phases while the link is idle.
// ----------------------------------------------------------------------------
module nibble_checked_command_link_tb
  import ncl_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_SLOTS     = QUEUE_DEPTH_DEF;
  localparam int HOLD_OFF_LEN   = 150;
  localparam int REPORT_LIMIT   = 10;
  localparam int SETTLE_CYCLES  = 4;

  typedef struct packed {
    ncl_command_t      cmd;
    logic [CODE_W-1:0] code;
    logic [DATA_W-1:0] data;
    logic [7:0]        b1;
    logic [7:0]        b2;
    logic              drain_first;
  } link_request_t;

  typedef struct packed {
    ncl_status_t       status;
    logic              tx_valid;
    logic [7:0]        tx1;
    logic [7:0]        tx2;
    ncl_event_t        ev_kind;
    logic [15:0]       ev_value;
    logic [CODE_W-1:0] rx_code;
    logic [DATA_W-1:0] rx_data;
  } link_outcome_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic              out_tx_valid;
  logic [7:0]        out_tx_first_byte;
  logic [7:0]        out_tx_second_byte;
  logic [1:0]        out_event_kind;
  logic [15:0]       out_event_value;
  logic [CODE_W-1:0] out_rx_code;
  logic [DATA_W-1:0] out_rx_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_link_enable = 1'b0;

  link_request_t driven_req = '0;
  logic          req_taken = 1'b0;

  link_request_t pending_requests[$];
  link_outcome_t expected_outcomes[$];
  int            mismatch_count = 0;

  logic [CODE_W-1:0] ring_code [RING_SLOTS];
  logic [DATA_W-1:0] ring_data [RING_SLOTS];
  int                ring_rd = 0;
  int                ring_wr = 0;
  logic [15:0]       alarm_word = '0;
  bit                link_on = 1'b1;

  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  bit long_hold_arm = 1'b0;
  bit long_hold_done = 1'b0;
  int hold_count = 0;

  nibble_checked_command_link #(
    .QUEUE_DEPTH(RING_SLOTS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (driven_req.cmd),
    .in_out_code       (driven_req.code),
    .in_out_data       (driven_req.data),
    .in_rx_first_byte  (driven_req.b1),
    .in_rx_second_byte (driven_req.b2),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_tx_valid      (out_tx_valid),
    .out_tx_first_byte (out_tx_first_byte),
    .out_tx_second_byte(out_tx_second_byte),
    .out_event_kind    (out_event_kind),
    .out_event_value   (out_event_value),
    .out_rx_code       (out_rx_code),
    .out_rx_data       (out_rx_data),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_link_enable   (cfg_link_enable)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic link_outcome_t predict_outcome(link_request_t rq);
    link_outcome_t     o;
    int                nxt;
    logic [3:0]        hi;
    logic [3:0]        inv_lo;
    logic [CODE_W-1:0] c;
    logic [DATA_W-1:0] d;
    o = '0;
    case (rq.cmd)
      CMD_QUEUE: begin
        nxt = (ring_wr + 1) % RING_SLOTS;
        if (!link_on || nxt == ring_rd) begin
          o.status = STS_REFUSED;
        end else begin
          ring_code[ring_wr] = rq.code;
          ring_data[ring_wr] = rq.data;
          ring_wr = nxt;
        end
      end
      CMD_RX: begin
        hi = rq.b1[7:4];
        inv_lo = ~rq.b2[3:0];
        if (hi != inv_lo) begin
          o.status = STS_MISMATCH;
        end else begin
          d = {rq.b1[3:0], rq.b2[7:4]};
          o.rx_code = hi;
          o.rx_data = d;
          if (hi == CODE_ALARM_LO) begin
            alarm_word[7:0] = d;
            o.ev_kind = EVT_ALARM;
            o.ev_value = alarm_word;
          end else if (hi == CODE_ALARM_HI) begin
            alarm_word[15:8] = d;
            o.ev_kind = EVT_ALARM;
            o.ev_value = alarm_word;
          end else if (hi == CODE_KEY) begin
            o.ev_kind = EVT_KEY;
            o.ev_value = {8'h00, d};
          end
        end
      end
      CMD_TX: begin
        if (ring_rd == ring_wr) begin
          o.status = STS_EMPTY;
        end else begin
          c = ring_code[ring_rd];
          d = ring_data[ring_rd];
          o.tx_valid = 1'b1;
          o.tx1 = {c, d[7:4]};
          o.tx2 = {d[3:0], ~c};
          ring_rd = (ring_rd + 1) % RING_SLOTS;
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  function automatic link_request_t request_of(ncl_command_t cmd, logic [3:0] code,
                                               logic [7:0] data, logic [7:0] b1,
                                               logic [7:0] b2);
    link_request_t r;
    r.cmd = cmd;
    r.code = code;
    r.data = data;
    r.b1 = b1;
    r.b2 = b2;
    r.drain_first = 1'b0;
    return r;
  endfunction

  function automatic link_request_t rx_frame(logic [3:0] c, logic [7:0] d);
    return request_of(CMD_RX, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                      {c, d[7:4]}, {d[3:0], ~c});
  endfunction

  function automatic link_request_t random_request(int queue_pct, int tx_pct);
    link_request_t r;
    int            pick;
    logic [3:0]    c;
    r = request_of(CMD_QUEUE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick < queue_pct) begin
      r.cmd = CMD_QUEUE;
    end else if (pick < queue_pct + tx_pct) begin
      r.cmd = CMD_TX;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        r.cmd = CMD_NONE;
      end else if (pick < 15) begin
        r.cmd = CMD_RX;
      end else begin
        case ($urandom_range(0, 5))
          0: c = CODE_ALARM_LO;
          1: c = CODE_ALARM_HI;
          2: c = CODE_KEY;
          default: c = 4'($urandom_range(0, 15));
        endcase
        r = rx_frame(c, 8'($urandom_range(0, 255)));
      end
    end
    return r;
  endfunction

  task automatic add_random(int count, int queue_pct, int tx_pct, bit pause_first);
    link_request_t r;
    for (int i = 0; i < count; i++) begin
      r = random_request(queue_pct, tx_pct);
      r.drain_first = pause_first && (i == 0);
      pending_requests.push_back(r);
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_link_enable(bit value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_link_enable = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    link_on = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !req_taken) begin
    end else if (gap_left > 0) begin
      gap_left = gap_left - 1;
      in_valid <= 1'b0;
    end else if (pending_requests.size() != 0 &&
                 !(pending_requests[0].drain_first && expected_outcomes.size() != 0)) begin
      driven_req <= pending_requests.pop_front();
      in_valid <= 1'b1;
      burst_left = burst_left - 1;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = $urandom_range(0, 6);
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (long_hold_arm && !long_hold_done) begin
      out_stall <= 1'b1;
      hold_count = hold_count + 1;
      if (hold_count >= HOLD_OFF_LEN) long_hold_done = 1'b1;
    end else begin
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 60);
      end
      mode_left = mode_left - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        2: out_stall <= ($urandom_range(0, 99) < 70);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    link_outcome_t seen;
    link_outcome_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen.status = ncl_status_t'(out_status);
        seen.tx_valid = out_tx_valid;
        seen.tx1 = out_tx_first_byte;
        seen.tx2 = out_tx_second_byte;
        seen.ev_kind = ncl_event_t'(out_event_kind);
        seen.ev_value = out_event_value;
        seen.rx_code = out_rx_code;
        seen.rx_data = out_rx_data;
        if (expected_outcomes.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result with no request outstanding: status %0h tx %0h %0h %0h",
                     $realtime, seen.status, seen.tx_valid, seen.tx1, seen.tx2);
        end else begin
          want = expected_outcomes.pop_front();
          if (seen !== want) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("%0t: mismatch status/txv/tx1/tx2/evk/evv/code/data", $realtime);
              $display("  expected %0h %0h %0h %0h %0h %0h %0h %0h", want.status,
                       want.tx_valid, want.tx1, want.tx2, want.ev_kind, want.ev_value,
                       want.rx_code, want.rx_data);
              $display("  actual   %0h %0h %0h %0h %0h %0h %0h %0h", seen.status,
                       seen.tx_valid, seen.tx1, seen.tx2, seen.ev_kind, seen.ev_value,
                       seen.rx_code, seen.rx_data);
            end
          end
        end
      end
      if (in_valid && !in_stall) expected_outcomes.push_back(predict_outcome(driven_req));
      req_taken <= in_valid && !in_stall;
    end else begin
      req_taken <= 1'b0;
    end
  end

  initial begin
    #3000000;
    $display("nibble_checked_command_link_tb: FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    pending_requests.push_back(request_of(CMD_TX, 4'h0, 8'h00, 8'h00, 8'h00));
    pending_requests.push_back(request_of(CMD_NONE, 4'hf, 8'hff, 8'hff, 8'hff));
    pending_requests.push_back(request_of(CMD_QUEUE, 4'h0, 8'h00, 8'h00, 8'h00));
    pending_requests.push_back(request_of(CMD_QUEUE, 4'hf, 8'hff, 8'hff, 8'hff));
    pending_requests.push_back(request_of(CMD_QUEUE, 4'ha, 8'h5a, 8'h00, 8'h00));
    repeat (4) pending_requests.push_back(request_of(CMD_TX, 4'h0, 8'h00, 8'h00, 8'h00));
    pending_requests.push_back(rx_frame(CODE_ALARM_LO, 8'hff));
    pending_requests.push_back(rx_frame(CODE_ALARM_HI, 8'h00));
    pending_requests.push_back(rx_frame(CODE_ALARM_HI, 8'ha5));
    pending_requests.push_back(rx_frame(CODE_ALARM_LO, 8'h3c));
    pending_requests.push_back(rx_frame(CODE_KEY, 8'h00));
    pending_requests.push_back(rx_frame(CODE_KEY, 8'hff));
    pending_requests.push_back(rx_frame(4'h0, 8'h00));
    pending_requests.push_back(rx_frame(4'hf, 8'hff));
    pending_requests.push_back(rx_frame(4'h9, 8'h81));
    pending_requests.push_back(request_of(CMD_RX, 4'h0, 8'h00, 8'h00, 8'h00));
    pending_requests.push_back(request_of(CMD_RX, 4'h0, 8'h00, 8'hff, 8'hff));
    pending_requests.push_back(request_of(CMD_RX, 4'h0, 8'h00, 8'h1e, 8'he1));
    pending_requests.push_back(request_of(CMD_NONE, 4'h0, 8'h00, 8'h00, 8'h00));
    wait_idle();

    write_link_enable(1'b0);
    pending_requests.push_back(request_of(CMD_QUEUE, 4'h3, 8'h33, 8'h00, 8'h00));
    pending_requests.push_back(request_of(CMD_TX, 4'h0, 8'h00, 8'h00, 8'h00));
    pending_requests.push_back(rx_frame(CODE_ALARM_LO, 8'h55));
    add_random(45, 40, 20, 1'b0);
    wait_idle();

    write_link_enable(1'b1);
    for (int seg = 0; seg < 5; seg++) begin
      if (seg % 2 == 0) add_random(60, 75, 5, seg == 2);
      else add_random(50, 10, 70, 1'b0);
    end
    long_hold_arm = 1'b1;
    wait_idle();

    write_link_enable(1'b0);
    add_random(80, 30, 40, 1'b0);
    wait_idle();

    write_link_enable(1'b1);
    add_random(320, 45, 30, 1'b0);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("nibble_checked_command_link_tb: PASS");
    end else begin
      $display("nibble_checked_command_link_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ nibble_checked_command_link.f @@
hdl/ncl_pkg.sv
hdl/ncl_ram.sv
hdl/ncl_ctrl.sv
hdl/ncl_dpath.sv
hdl/nibble_checked_command_link.sv
hdl/ncl_checker.sv
verif/nibble_checked_command_link_tb.sv
